// File: rtl/core/qse_pkg.sv
// qse_pkg: shared constants, beat types, controller states and the
// command/status structs of the quicksort engine. No dependencies.
package qse_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_set;
    } out_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } span_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SETUP,
        ST_POP,
        ST_RANGE,
        ST_PIVOT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_SWP,
        ST_FIN_RD,
        ST_FIN_WR1,
        ST_FIN_WR2,
        ST_PUSH_LO,
        ST_PUSH_HI,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic start;
        logic pop;
        logic range_ld;
        logic pivot_ld;
        logic scan_rd;
        logic swap_lo;
        logic swap_hi;
        logic scan_skip;
        logic fin_rd;
        logic fin_wr_lo;
        logic fin_wr_mid;
        logic push_left;
        logic push_right;
        logic emit_start;
        logic emit_rd;
        logic emit_ld;
    } cmd_t;

    typedef struct packed {
        logic in_end;
        logic stack_empty;
        logic scan_done;
        logic less;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/quicksort_engine.sv
// quicksort_engine: loads up to DEPTH signed words, sorts them by quicksort, emits them.
// Load: one beat per cycle. Sort: each range is partitioned about its first entry as pivot,
// scanning its other entries and swapping those less than the pivot; the first result beat
// follows the last partition. Emit: per beat a registered store read, then the output
// register once it is free (empty or m_ready); a beat is read only after the one before it is loaded.
// Reset (aresetn low, synchronous) returns to loading with an empty set; store not cleared.
module quicksort_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  qse_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output qse_pkg::out_beat_t m_data
);
    import qse_pkg::*;

    cmd_t cmd;
    sts_t sts;

    qse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    qse_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    a_last_stops_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.is_last) |=> !s_ready)
        else $error("load continued after last beat");

    a_load_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) |-> $past(cmd.emit_ld && sts.emit_last))
        else $error("returned to load without final beat");

    a_end_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_ld && sts.emit_last) |=> (m_valid && m_data.end_of_set))
        else $error("final beat not marked");
`endif

endmodule

// File: rtl/core/qse_ctrl.sv
// qse_ctrl: sequencer of the quicksort engine (load, partition, emit).
// Depends on qse_pkg; drives commands into qse_dpath, reads its status.
module qse_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  qse_pkg::sts_t sts,
    output qse_pkg::cmd_t cmd
);
    import qse_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == ST_LOAD);
        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    cmd.load_wr = 1'b1;
                    if (sts.in_end) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                cmd.start  = 1'b1;
                state_next = ST_POP;
            end
            ST_POP: begin
                if (sts.stack_empty) begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT_RD;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                cmd.range_ld = 1'b1;
                state_next   = ST_PIVOT;
            end
            ST_PIVOT: begin
                cmd.pivot_ld = 1'b1;
                state_next   = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                if (sts.scan_done) begin
                    state_next = ST_FIN_RD;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (sts.less) begin
                    cmd.swap_lo = 1'b1;
                    state_next  = ST_SCAN_SWP;
                end else begin
                    cmd.scan_skip = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_SCAN_SWP: begin
                cmd.swap_hi = 1'b1;
                state_next  = ST_SCAN_RD;
            end
            ST_FIN_RD: begin
                cmd.fin_rd = 1'b1;
                state_next = ST_FIN_WR1;
            end
            ST_FIN_WR1: begin
                cmd.fin_wr_lo = 1'b1;
                state_next    = ST_FIN_WR2;
            end
            ST_FIN_WR2: begin
                cmd.fin_wr_mid = 1'b1;
                state_next     = ST_PUSH_LO;
            end
            ST_PUSH_LO: begin
                cmd.push_left = 1'b1;
                state_next    = ST_PUSH_HI;
            end
            ST_PUSH_HI: begin
                cmd.push_right = 1'b1;
                state_next     = ST_POP;
            end
            ST_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (sts.out_free) begin
                    cmd.emit_ld = 1'b1;
                    state_next  = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// File: rtl/core/qse_dpath.sv
// qse_dpath: element store, range stack, partition pointers and output register.
// Depends on qse_pkg; executes commands from qse_ctrl.
module qse_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  qse_pkg::in_beat_t s_data,
    input  qse_pkg::cmd_t     cmd,
    output qse_pkg::sts_t     sts,
    output logic              m_valid,
    input  logic              m_ready,
    output qse_pkg::out_beat_t m_data
);
    import qse_pkg::*;

    logic [DATA_W-1:0] elem_mem [DEPTH];
    span_t             stk_mem  [DEPTH];

    logic [IDX_W-1:0]         count_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         top_reg;
    span_t                    stk_rd_reg;
    logic [IDX_W-1:0]         lo_reg;
    logic [IDX_W-1:0]         hi_reg;
    logic [IDX_W-1:0]         b_reg;
    logic [CNT_W-1:0]         s_reg;
    logic [IDX_W-1:0]         k_reg;
    logic signed [DATA_W-1:0] pivot_reg;
    logic signed [DATA_W-1:0] rd_a_reg;
    logic signed [DATA_W-1:0] rd_b_reg;
    logic                     m_valid_reg;
    out_beat_t                m_data_reg;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re_a;
    logic [IDX_W-1:0]  raddr_a;
    logic              re_b;
    logic [IDX_W-1:0]  raddr_b;
    logic [IDX_W-1:0]  b_inc;
    logic [IDX_W-1:0]  s_idx;

    logic              stk_we;
    span_t             stk_wdata;
    logic              stk_room;
    logic              left_ok;
    logic              right_ok;

    assign b_inc    = b_reg + IDX_W'(1);
    assign s_idx    = s_reg[IDX_W-1:0];
    assign stk_room = (top_reg < CNT_W'(DEPTH));
    assign left_ok  = ({1'b0, b_reg} > ({1'b0, lo_reg} + CNT_W'(1)));
    assign right_ok = (({1'b0, b_reg} + CNT_W'(1)) < {1'b0, hi_reg});

    assign sts.in_end      = s_data.is_last || (count_reg == IDX_W'(DEPTH - 1));
    assign sts.stack_empty = (top_reg == '0);
    assign sts.scan_done   = (s_reg > {1'b0, hi_reg});
    assign sts.less        = (rd_a_reg < pivot_reg);
    assign sts.emit_last   = ({1'b0, k_reg} == (n_reg - CNT_W'(1)));
    assign sts.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // element store port selection
    always_comb begin
        we      = 1'b0;
        waddr   = count_reg;
        wdata   = s_data.value;
        re_a    = 1'b0;
        raddr_a = s_idx;
        re_b    = 1'b0;
        raddr_b = b_inc;
        if (cmd.load_wr) begin
            we = 1'b1;
        end
        if (cmd.swap_lo) begin
            we    = 1'b1;
            waddr = b_inc;
            wdata = rd_a_reg;
        end
        if (cmd.swap_hi) begin
            we    = 1'b1;
            waddr = s_idx;
            wdata = rd_b_reg;
        end
        if (cmd.fin_wr_lo) begin
            we    = 1'b1;
            waddr = lo_reg;
            wdata = rd_b_reg;
        end
        if (cmd.fin_wr_mid) begin
            we    = 1'b1;
            waddr = b_reg;
            wdata = pivot_reg;
        end
        if (cmd.range_ld) begin
            re_a    = 1'b1;
            raddr_a = stk_rd_reg.lo;
        end
        if (cmd.scan_rd) begin
            re_a = 1'b1;
            re_b = 1'b1;
        end
        if (cmd.fin_rd) begin
            re_b    = 1'b1;
            raddr_b = b_reg;
        end
        if (cmd.emit_rd) begin
            re_a    = 1'b1;
            raddr_a = k_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            elem_mem[waddr] <= wdata;
        end
        if (re_a) begin
            rd_a_reg <= elem_mem[raddr_a];
        end
        if (re_b) begin
            rd_b_reg <= elem_mem[raddr_b];
        end
    end

    // range stack
    always_comb begin
        stk_we    = 1'b0;
        stk_wdata = '{lo: '0, hi: n_reg[IDX_W-1:0] - IDX_W'(1)};
        if (cmd.start) begin
            stk_we = (n_reg > CNT_W'(1));
        end
        if (cmd.push_left) begin
            stk_we    = left_ok && stk_room;
            stk_wdata = '{lo: lo_reg, hi: b_reg - IDX_W'(1)};
        end
        if (cmd.push_right) begin
            stk_we    = right_ok && stk_room;
            stk_wdata = '{lo: b_inc, hi: hi_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[top_reg[IDX_W-1:0]] <= stk_wdata;
        end
        if (cmd.pop) begin
            stk_rd_reg <= stk_mem[top_reg[IDX_W-1:0] - IDX_W'(1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            n_reg       <= '0;
            top_reg     <= '0;
            b_reg       <= '0;
            s_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_wr) begin
                if (sts.in_end) begin
                    count_reg <= '0;
                    n_reg     <= {1'b0, count_reg} + CNT_W'(1);
                end else begin
                    count_reg <= count_reg + IDX_W'(1);
                end
            end
            if (stk_we) begin
                top_reg <= top_reg + CNT_W'(1);
            end else if (cmd.pop) begin
                top_reg <= top_reg - CNT_W'(1);
            end
            if (cmd.pivot_ld) begin
                b_reg <= lo_reg;
                s_reg <= {1'b0, lo_reg} + CNT_W'(1);
            end
            if (cmd.scan_skip) begin
                s_reg <= s_reg + CNT_W'(1);
            end
            if (cmd.swap_hi) begin
                b_reg <= b_inc;
                s_reg <= s_reg + CNT_W'(1);
            end
            if (cmd.emit_start) begin
                k_reg <= '0;
            end else if (cmd.emit_ld) begin
                k_reg <= k_reg + IDX_W'(1);
            end
            if (cmd.emit_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.range_ld) begin
            lo_reg <= stk_rd_reg.lo;
            hi_reg <= stk_rd_reg.hi;
        end
        if (cmd.pivot_ld) begin
            pivot_reg <= rd_a_reg;
        end
        if (cmd.emit_ld) begin
            m_data_reg.sorted_value <= rd_a_reg;
            m_data_reg.end_of_set   <= sts.emit_last;
        end
    end

endmodule
